FILE: rtl/core/oct_pkg.sv
package oct_pkg;

    // Countdown sizing.
    localparam int SECONDS_WIDTH = 16;
    localparam int MS_PER_SECOND = 1000;
    localparam int SUB_MS_WIDTH  = $clog2(MS_PER_SECOND);

    // Alarm pattern timing in milliseconds.
    localparam int ALARM_PERIOD  = 1000;
    localparam int BEEP_SPACING  = 100;
    localparam int BEEP_LENGTH   = 50;
    localparam int BLINK_SLOT    = 250;
    localparam int PHASE_WIDTH   = $clog2(ALARM_PERIOD);

    // Item commands.
    localparam logic [1:0] CMD_POLL  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Orientation codes.
    localparam logic [2:0] FACE_UNKNOWN = 3'd0;
    localparam logic [2:0] FACE_UP      = 3'd1;
    localparam logic [2:0] FACE_DOWN    = 3'd2;
    localparam logic [2:0] FACE_LEFT    = 3'd3;
    localparam logic [2:0] FACE_RIGHT   = 3'd4;
    localparam logic [2:0] FACE_FRONT   = 3'd5;
    localparam logic [2:0] FACE_BACK    = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_BACK_SECONDS   = 3'd0;
    localparam logic [2:0] REG_UP_SECONDS     = 3'd1;
    localparam logic [2:0] REG_DOWN_SECONDS   = 3'd2;
    localparam logic [2:0] REG_LEFT_SECONDS   = 3'd3;
    localparam logic [2:0] REG_RIGHT_SECONDS  = 3'd4;
    localparam logic [2:0] REG_COMMIT_POLLS   = 3'd5;
    localparam logic [2:0] REG_SLEEP_POLLS    = 3'd6;
    localparam logic [2:0] REG_WAKE_INHIBIT   = 3'd7;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] orientation;
        logic       from_wake;
    } item_t;

    typedef struct packed {
        logic        beep;
        logic        text_visible;
        logic [15:0] remain_shown;
        logic        alarming;
        logic        standby_request;
        logic        face_applied;
        logic [1:0]  screen_dir;
        logic [2:0]  committed_code;
    } result_t;

endpackage

FILE: rtl/core/orientation_countdown_timer.sv
// Orientation countdown timer. Items arrive on the item channel (poll, millisecond
// tick or start) and each one yields exactly one result item. The block is a two-stage
// pipeline, an input register followed by a result register, and takes a new item
// every clock cycle while item_stall is low; an accepted item goes from the input
// register to the result register, and a stalled result stalls the input register
// only once both stages are full. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata and must only be changed while no items are in flight.
module orientation_countdown_timer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  oct_pkg::item_t                       item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output oct_pkg::result_t                     result,
    input  logic                                 cfg_we,
    input  logic [oct_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [oct_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);
    import oct_pkg::*;

    localparam int SW = SECONDS_WIDTH;
    localparam logic [24:0] SEC_MAX = 25'((64'd1 << SW) - 64'd1);

    // Configuration registers.
    logic [15:0] back_seconds_reg, up_seconds_reg, down_seconds_reg;
    logic [15:0] left_seconds_reg, right_seconds_reg;
    logic [7:0]  commit_polls_reg, sleep_polls_reg, wake_inhibit_reg;

    // Timer state.
    logic [2:0]              last_orient_reg, committed_face_reg;
    logic [7:0]              face_count_reg, front_count_reg, inhibit_count_reg;
    logic                    timer_active_reg, alarm_on_reg;
    logic [SW-1:0]           remain_sec_reg;
    logic [SUB_MS_WIDTH-1:0] sub_ms_reg;
    logic [PHASE_WIDTH-1:0]  alarm_phase_reg;
    logic [1:0]              rotation_reg;

    // Pipeline registers.
    logic    stage_valid_reg;
    item_t   stage_item_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    advance;
    logic    stage_move;

    // Next values.
    logic [2:0]              last_orient_next, committed_face_next;
    logic [7:0]              face_count_next, front_count_next, inhibit_count_next;
    logic                    timer_active_next, alarm_on_next;
    logic [SW-1:0]           remain_sec_next;
    logic [SUB_MS_WIDTH-1:0] sub_ms_next;
    logic [PHASE_WIDTH-1:0]  alarm_phase_next;
    logic [1:0]              rotation_next;
    result_t                 out_next;

    // Handshake: the result register frees up when empty or taken.
    assign advance      = !out_valid_reg || !result_stall;
    assign stage_move   = stage_valid_reg && advance;
    assign item_stall   = stage_valid_reg && !advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Countdown length for a face; zero marks a face without a timer.
    function automatic logic [15:0] face_seconds(input logic [2:0] f,
        input logic [15:0] bk, input logic [15:0] up, input logic [15:0] dn,
        input logic [15:0] lf, input logic [15:0] rt);
        logic [15:0] s;
        s = 16'd0;
        if (f == FACE_BACK)  s = bk;
        if (f == FACE_UP)    s = up;
        if (f == FACE_DOWN)  s = dn;
        if (f == FACE_LEFT)  s = lf;
        if (f == FACE_RIGHT) s = rt;
        return s;
    endfunction

    // Per-item state update and result.
    always_comb begin
        logic [2:0]              o;
        logic [15:0]             secs;
        logic [24:0]             secs_ext;
        logic [SUB_MS_WIDTH:0]   sub_inc;
        logic [PHASE_WIDTH:0]    phase_inc;
        logic [PHASE_WIDTH-1:0]  t;
        logic                    beep, standby, applied, visible;
        logic [SW-1:0]           shown;

        last_orient_next    = last_orient_reg;
        committed_face_next = committed_face_reg;
        face_count_next     = face_count_reg;
        front_count_next    = front_count_reg;
        inhibit_count_next  = inhibit_count_reg;
        timer_active_next   = timer_active_reg;
        alarm_on_next       = alarm_on_reg;
        remain_sec_next     = remain_sec_reg;
        sub_ms_next         = sub_ms_reg;
        alarm_phase_next    = alarm_phase_reg;
        rotation_next       = rotation_reg;
        beep     = 1'b0;
        standby  = 1'b0;
        applied  = 1'b0;
        visible  = 1'b1;
        shown    = '0;
        t        = alarm_phase_reg;
        o        = (stage_item_reg.orientation > FACE_BACK) ? FACE_UNKNOWN
                                                           : stage_item_reg.orientation;
        secs     = face_seconds(o, back_seconds_reg, up_seconds_reg, down_seconds_reg,
                                left_seconds_reg, right_seconds_reg);
        secs_ext = 25'(secs);
        sub_inc  = {1'b0, sub_ms_reg} + 1'b1;
        phase_inc = {1'b0, alarm_phase_reg} + 1'b1;

        unique case (stage_item_reg.cmd)
            CMD_START:
            begin
                last_orient_next    = FACE_UNKNOWN;
                committed_face_next = FACE_UNKNOWN;
                face_count_next     = 8'd0;
                front_count_next    = 8'd0;
                inhibit_count_next  = stage_item_reg.from_wake ? wake_inhibit_reg : 8'd0;
                timer_active_next   = 1'b0;
                alarm_on_next       = 1'b0;
                remain_sec_next     = '0;
                sub_ms_next         = '0;
                alarm_phase_next    = '0;
                rotation_next       = 2'd0;
            end
            CMD_POLL:
            begin
                if (inhibit_count_reg != 8'd0)
                    inhibit_count_next = inhibit_count_reg - 8'd1;
                if (o != last_orient_reg)
                begin
                    face_count_next  = 8'd0;
                    front_count_next = 8'd0;
                end
                last_orient_next = o;
                if (o == FACE_FRONT)
                begin
                    face_count_next = 8'd0;
                    if (inhibit_count_next == 8'd0)
                    begin
                        if (front_count_next < sleep_polls_reg)
                            front_count_next = front_count_next + 8'd1;
                        if (front_count_next >= sleep_polls_reg)
                        begin
                            standby          = 1'b1;
                            alarm_on_next    = 1'b0;
                            alarm_phase_next = '0;
                        end
                    end
                end
                else if (secs != 16'd0)
                begin
                    front_count_next = 8'd0;
                    if (face_count_next < commit_polls_reg)
                        face_count_next = face_count_next + 8'd1;
                    if (face_count_next >= commit_polls_reg && o != committed_face_reg)
                    begin
                        // Commit the face and restart the countdown.
                        applied             = 1'b1;
                        committed_face_next = o;
                        alarm_on_next       = 1'b0;
                        alarm_phase_next    = '0;
                        remain_sec_next     = (secs_ext > SEC_MAX) ? SW'(SEC_MAX)
                                                                   : SW'(secs_ext);
                        sub_ms_next         = '0;
                        timer_active_next   = 1'b1;
                        if (o == FACE_UP)    rotation_next = 2'd2;
                        if (o == FACE_DOWN)  rotation_next = 2'd0;
                        if (o == FACE_LEFT)  rotation_next = 2'd1;
                        if (o == FACE_RIGHT) rotation_next = 2'd3;
                    end
                end
                else
                begin
                    front_count_next = 8'd0;
                    face_count_next  = 8'd0;
                end
                // A countdown that has run out turns into the alarm.
                if (timer_active_next && remain_sec_next == '0)
                begin
                    timer_active_next = 1'b0;
                    sub_ms_next       = '0;
                    alarm_on_next     = 1'b1;
                    alarm_phase_next  = '0;
                end
            end
            CMD_TICK:
            begin
                if (timer_active_reg && remain_sec_reg != '0)
                begin
                    if (sub_inc >= (SUB_MS_WIDTH+1)'(MS_PER_SECOND))
                    begin
                        sub_ms_next     = '0;
                        remain_sec_next = remain_sec_reg - 1'b1;
                    end
                    else
                    begin
                        sub_ms_next = sub_inc[SUB_MS_WIDTH-1:0];
                    end
                end
                if (alarm_on_reg)
                begin
                    // Four beeps of 50 ms at a 100 ms spacing, then quiet.
                    beep = (t < PHASE_WIDTH'(BEEP_LENGTH))
                        || (t >= PHASE_WIDTH'(BEEP_SPACING)
                            && t < PHASE_WIDTH'(BEEP_SPACING + BEEP_LENGTH))
                        || (t >= PHASE_WIDTH'(2*BEEP_SPACING)
                            && t < PHASE_WIDTH'(2*BEEP_SPACING + BEEP_LENGTH))
                        || (t >= PHASE_WIDTH'(3*BEEP_SPACING)
                            && t < PHASE_WIDTH'(3*BEEP_SPACING + BEEP_LENGTH));
                    alarm_phase_next = (phase_inc >= (PHASE_WIDTH+1)'(ALARM_PERIOD))
                                       ? '0 : phase_inc[PHASE_WIDTH-1:0];
                end
            end
            default:
            begin
                // Unused command leaves the state alone.
            end
        endcase

        // Text blinks in 250 ms slots while alarming.
        if (alarm_on_next)
            visible = (alarm_phase_next < PHASE_WIDTH'(BLINK_SLOT))
                   || (alarm_phase_next >= PHASE_WIDTH'(2*BLINK_SLOT)
                       && alarm_phase_next < PHASE_WIDTH'(3*BLINK_SLOT));
        else if (timer_active_next)
            shown = remain_sec_next;

        out_next.beep            = beep;
        out_next.text_visible    = visible;
        out_next.remain_shown    = 16'(shown);
        out_next.alarming        = alarm_on_next;
        out_next.standby_request = standby;
        out_next.face_applied    = applied;
        out_next.screen_dir      = rotation_next;
        out_next.committed_code  = committed_face_next;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_seconds_reg  <= 16'd300;
            up_seconds_reg    <= 16'd600;
            down_seconds_reg  <= 16'd900;
            left_seconds_reg  <= 16'd1200;
            right_seconds_reg <= 16'd1800;
            commit_polls_reg  <= 8'd4;
            sleep_polls_reg   <= 8'd8;
            wake_inhibit_reg  <= 8'd12;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BACK_SECONDS:  back_seconds_reg  <= cfg_wdata;
                REG_UP_SECONDS:    up_seconds_reg    <= cfg_wdata;
                REG_DOWN_SECONDS:  down_seconds_reg  <= cfg_wdata;
                REG_LEFT_SECONDS:  left_seconds_reg  <= cfg_wdata;
                REG_RIGHT_SECONDS: right_seconds_reg <= cfg_wdata;
                REG_COMMIT_POLLS:  commit_polls_reg  <= cfg_wdata[7:0];
                REG_SLEEP_POLLS:   sleep_polls_reg   <= cfg_wdata[7:0];
                REG_WAKE_INHIBIT:  wake_inhibit_reg  <= cfg_wdata[7:0];
                default:           back_seconds_reg  <= back_seconds_reg;
            endcase
        end
    end

    // Timer state advances when an item moves from the input register to the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_orient_reg    <= FACE_UNKNOWN;
            committed_face_reg <= FACE_UNKNOWN;
            face_count_reg     <= 8'd0;
            front_count_reg    <= 8'd0;
            inhibit_count_reg  <= 8'd0;
            timer_active_reg   <= 1'b0;
            alarm_on_reg       <= 1'b0;
            remain_sec_reg     <= '0;
            sub_ms_reg         <= '0;
            alarm_phase_reg    <= '0;
            rotation_reg       <= 2'd0;
        end
        else if (stage_move)
        begin
            last_orient_reg    <= last_orient_next;
            committed_face_reg <= committed_face_next;
            face_count_reg     <= face_count_next;
            front_count_reg    <= front_count_next;
            inhibit_count_reg  <= inhibit_count_next;
            timer_active_reg   <= timer_active_next;
            alarm_on_reg       <= alarm_on_next;
            remain_sec_reg     <= remain_sec_next;
            sub_ms_reg         <= sub_ms_next;
            alarm_phase_reg    <= alarm_phase_next;
            rotation_reg       <= rotation_next;
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (!item_stall)
                stage_valid_reg <= item_valid;
            if (advance)
                out_valid_reg <= stage_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            stage_item_reg <= item;
        if (stage_move)
            out_reg <= out_next;
    end

    // The timer and the alarm never run together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(timer_active_reg && alarm_on_reg))
        else $error("timer and alarm active together");

    // Counters stay inside their periods.
    assert property (@(posedge clk) disable iff (!rst_n)
        sub_ms_reg < SUB_MS_WIDTH'(MS_PER_SECOND)
        && alarm_phase_reg < PHASE_WIDTH'(ALARM_PERIOD))
        else $error("millisecond or alarm phase counter out of range");

    // A committed face is always a timer face.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.face_applied) |->
        (out_reg.committed_code != FACE_UNKNOWN && out_reg.committed_code != FACE_FRONT
         && !out_reg.standby_request))
        else $error("face applied with a non-timer face or with standby");

    // Hidden text only happens while alarming.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.text_visible) |-> out_reg.alarming)
        else $error("text hidden without an alarm");

    // A stalled input item stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> stage_valid_reg)
        else $error("stalled input item dropped");

endmodule
